// ===== design/mtt_pkg.sv =====
// ----------------------------------------------------------------------------
// mtt_pkg
// shared constants, field widths and codes for the multi-slot timer table
// ----------------------------------------------------------------------------
package mtt_pkg;

    // table geometry
    localparam int SLOTS       = 8;
    localparam int MAX_RESULTS = 8;
    localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    // field widths
    localparam int MODE_W   = 2;
    localparam int SLOT_W   = 3;
    localparam int WORD_W   = 32;
    localparam int ACTION_W = 8;
    localparam int KIND_W   = 3;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 48;

    // input item modes
    localparam logic [MODE_W-1:0] MODE_ATTACH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DETACH  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SERVICE = 2'd3;

    // result item kinds
    localparam logic [KIND_W-1:0] KIND_ATTACH = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DETACH = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIRE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NONE   = 3'd4;

endpackage

// ===== design/multi_slot_soft_timer_table.sv =====
// ----------------------------------------------------------------------------
// multi_slot_soft_timer_table
// table of one-shot and periodic software timers with attach, detach,
// tick and service items, walked one slot per cycle by a shared unit;
// the service walk holds at a ready slot while the output register is busy
// attach and detach: ST_ATT or ST_DET registers the result once the output is free
// tick: one slot per cycle through the shared decrement unit, then ST_TACK
// service: fire results leave from ST_SVC; ST_NONE reports when nothing fires
// one item at a time: s_tready is high only while the sequencer is idle
// asynchronous active-low reset clears the active and ready marks and control;
// slot payload words are never read before an attach writes them
module multi_slot_soft_timer_table
(
    input  logic                          clk,
    input  logic                          rst_n,
    // input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // slot[2:0], have_slot[3], period[35:4], start_count[67:36],
    // action[75:68], user_arg[107:76], zero pad[111:108]
    input  logic [mtt_pkg::S_TDATA_W-1:0] s_tdata,
    // mode[1:0]
    input  logic [mtt_pkg::MODE_W-1:0]    s_tuser,
    // result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // ok[0], out_slot[3:1], out_action[11:4], out_arg[43:12], freed[44],
    // zero pad[47:45]
    output logic [mtt_pkg::M_TDATA_W-1:0] m_tdata,
    // kind[2:0]
    output logic [mtt_pkg::KIND_W-1:0]    m_tuser,
    output logic                          m_tlast
);
    import mtt_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ATT  = 3'd1;
    localparam logic [2:0] ST_DET  = 3'd2;
    localparam logic [2:0] ST_TICK = 3'd3;
    localparam logic [2:0] ST_TACK = 3'd4;
    localparam logic [2:0] ST_SVC  = 3'd5;
    localparam logic [2:0] ST_NONE = 3'd6;

    // control state
    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [NRES_W-1:0] nres_reg, nres_next;
    logic [SLOTS-1:0]  active_reg, active_next;
    logic [SLOTS-1:0]  ready_reg, ready_next;

    // slot payload, one entry per slot, single read index
    logic [WORD_W-1:0]   period_reg [SLOTS];
    logic [WORD_W-1:0]   count_reg  [SLOTS];
    logic [ACTION_W-1:0] action_reg [SLOTS];
    logic [WORD_W-1:0]   arg_reg    [SLOTS];

    // captured input item
    logic [MODE_W-1:0]   mode_reg;
    logic [SLOT_W-1:0]   slot_in_reg;
    logic                have_reg;
    logic [WORD_W-1:0]   per_in_reg;
    logic [WORD_W-1:0]   cnt_in_reg;
    logic [ACTION_W-1:0] act_in_reg;
    logic [WORD_W-1:0]   arg_in_reg;

    // output register
    logic                m_tvalid_reg, m_tvalid_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic                ok_reg, ok_next;
    logic [SLOT_W-1:0]   oslot_reg, oslot_next;
    logic [ACTION_W-1:0] oact_reg, oact_next;
    logic [WORD_W-1:0]   oarg_reg, oarg_next;
    logic                freed_reg, freed_next;
    logic                last_reg, last_next;

    // payload write controls
    logic                pay_we;
    logic [IDX_W-1:0]    pay_idx;
    logic                cnt_we;
    logic [WORD_W-1:0]   cnt_wdata;

    // helpers
    logic                take;
    logic                out_free;
    logic                in_range;
    logic [IDX_W-1:0]    held_idx;
    logic                held;
    logic                free_any;
    logic [IDX_W-1:0]    free_idx;
    logic [WORD_W-1:0]   rd_cnt;
    logic [WORD_W-1:0]   rd_per;
    logic [WORD_W-1:0]   cnt_dec;
    logic                cnt_hit;
    logic [SLOTS-1:0]    above;
    logic                fire_cand;
    logic                fire_go;
    logic                fire_freed;
    logic                walk_end;

    assign take     = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // the caller holds a slot only if it names an active one in range
    assign in_range = (32'(slot_in_reg) < SLOTS);
    assign held_idx = IDX_W'(slot_in_reg);
    assign held     = have_reg && in_range && active_reg[held_idx];

    // lowest free slot
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // shared unit: one decrement and zero test per cycle at the walk index
    assign rd_cnt   = count_reg[idx_reg];
    assign rd_per   = period_reg[idx_reg];
    assign cnt_dec  = (rd_cnt == '0) ? '0 : rd_cnt - 1'b1;
    assign cnt_hit  = (cnt_dec == '0);
    assign walk_end = (32'(idx_reg) == SLOTS - 1);

    // slots above the walk index, for the last mark on a fire
    always_comb
    begin
        for (int j = 0; j < SLOTS; j++)
        begin
            above[j] = (j > int'(idx_reg));
        end
    end

    assign fire_cand  = active_reg[idx_reg] && ready_reg[idx_reg]
                        && (nres_reg < NRES_W'(MAX_RESULTS));
    assign fire_go    = (state_reg == ST_SVC) && fire_cand && out_free;
    assign fire_freed = (rd_per == '0) && (rd_cnt == '0);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        nres_next     = nres_reg;
        active_next   = active_reg;
        ready_next    = ready_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        kind_next     = kind_reg;
        ok_next       = ok_reg;
        oslot_next    = oslot_reg;
        oact_next     = oact_reg;
        oarg_next     = oarg_reg;
        freed_next    = freed_reg;
        last_next     = last_reg;
        pay_we        = 1'b0;
        pay_idx       = held_idx;
        cnt_we        = 1'b0;
        cnt_wdata     = cnt_dec;

        case (state_reg)
            ST_IDLE:
            begin
                idx_next  = '0;
                nres_next = '0;
                if (take)
                begin
                    case (s_tuser)
                        MODE_ATTACH:  state_next = ST_ATT;
                        MODE_DETACH:  state_next = ST_DET;
                        MODE_TICK:    state_next = ST_TICK;
                        MODE_SERVICE: state_next = ST_SVC;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end

            ST_ATT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    kind_next     = KIND_ATTACH;
                    ok_next       = 1'b0;
                    oslot_next    = '0;
                    oact_next     = '0;
                    oarg_next     = '0;
                    freed_next    = 1'b0;
                    last_next     = 1'b1;
                    if (act_in_reg == '0)
                    begin
                        // null action fails
                    end
                    else if (held)
                    begin
                        // update in place, ready mark dropped
                        pay_we               = 1'b1;
                        pay_idx              = held_idx;
                        ready_next[held_idx] = 1'b0;
                        ok_next              = 1'b1;
                        oslot_next           = slot_in_reg;
                    end
                    else if (free_any)
                    begin
                        pay_we                = 1'b1;
                        pay_idx               = free_idx;
                        active_next[free_idx] = 1'b1;
                        ready_next[free_idx]  = (cnt_in_reg == '0);
                        ok_next               = 1'b1;
                        oslot_next            = SLOT_W'(free_idx);
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_DET:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    kind_next     = KIND_DETACH;
                    ok_next       = held;
                    oslot_next    = slot_in_reg;
                    oact_next     = '0;
                    oarg_next     = '0;
                    freed_next    = 1'b0;
                    last_next     = 1'b1;
                    if (held)
                    begin
                        active_next[held_idx] = 1'b0;
                        ready_next[held_idx]  = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_TICK:
            begin
                if (active_reg[idx_reg])
                begin
                    cnt_we = 1'b1;
                    if (cnt_hit)
                    begin
                        // expired: mark ready and reload
                        ready_next[idx_reg] = 1'b1;
                        cnt_wdata           = rd_per;
                    end
                end
                if (walk_end)
                begin
                    state_next = ST_TACK;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_TACK:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    kind_next     = KIND_TICK;
                    ok_next       = 1'b0;
                    oslot_next    = '0;
                    oact_next     = '0;
                    oarg_next     = '0;
                    freed_next    = 1'b0;
                    last_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            ST_SVC:
            begin
                // a ready slot waits here until the output register frees up
                if (!fire_cand || out_free)
                begin
                    if (fire_cand)
                    begin
                        m_tvalid_next       = 1'b1;
                        kind_next           = KIND_FIRE;
                        ok_next             = 1'b0;
                        oslot_next          = SLOT_W'(idx_reg);
                        oact_next           = action_reg[idx_reg];
                        oarg_next           = arg_reg[idx_reg];
                        freed_next          = fire_freed;
                        last_next           = (nres_reg == NRES_W'(MAX_RESULTS - 1))
                                              || !(|(active_reg & ready_reg & above));
                        ready_next[idx_reg] = 1'b0;
                        if (fire_freed)
                        begin
                            active_next[idx_reg] = 1'b0;
                        end
                        nres_next = nres_reg + 1'b1;
                    end
                    if (walk_end)
                    begin
                        if (!fire_cand && (nres_reg == '0))
                        begin
                            state_next = ST_NONE;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            ST_NONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    kind_next     = KIND_NONE;
                    ok_next       = 1'b0;
                    oslot_next    = '0;
                    oact_next     = '0;
                    oarg_next     = '0;
                    freed_next    = 1'b0;
                    last_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            nres_reg     <= '0;
            active_reg   <= '0;
            ready_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            nres_reg     <= nres_next;
            active_reg   <= active_next;
            ready_reg    <= ready_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        ok_reg    <= ok_next;
        oslot_reg <= oslot_next;
        oact_reg  <= oact_next;
        oarg_reg  <= oarg_next;
        freed_reg <= freed_next;
        last_reg  <= last_next;
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mode_reg    <= s_tuser;
            slot_in_reg <= s_tdata[2:0];
            have_reg    <= s_tdata[3];
            per_in_reg  <= s_tdata[35:4];
            cnt_in_reg  <= s_tdata[67:36];
            act_in_reg  <= s_tdata[75:68];
            arg_in_reg  <= s_tdata[107:76];
        end
    end

    // slot payload writes; a released slot keeps stale words until re-attach
    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            period_reg[pay_idx] <= per_in_reg;
            count_reg[pay_idx]  <= cnt_in_reg;
            action_reg[pay_idx] <= act_in_reg;
            arg_reg[pay_idx]    <= arg_in_reg;
        end
        else if (cnt_we)
        begin
            count_reg[idx_reg] <= cnt_wdata;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {3'b000, freed_reg, oarg_reg, oact_reg, oslot_reg, ok_reg};

    // checks

    // a fired slot loses its ready mark
    assert property (@(posedge clk) disable iff (!rst_n)
        fire_go |=> !ready_reg[$past(idx_reg)])
        else $error("fired slot still ready");

    // the fire count of one service item stays within its limit
    assert property (@(posedge clk) disable iff (!rst_n)
        nres_reg <= NRES_W'(MAX_RESULTS))
        else $error("too many fire results");

    // only a fire result can report a released slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && freed_reg) |-> (kind_reg == KIND_FIRE))
        else $error("freed set on a non-fire result");

    // ready slots are always active
    assert property (@(posedge clk) disable iff (!rst_n)
        (ready_reg & ~active_reg) == '0)
        else $error("ready mark on an inactive slot");

    // a tick walk only runs with a captured tick mode
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TICK) |-> (mode_reg == MODE_TICK))
        else $error("tick walk without a tick item");

endmodule
